// ----- design/mpfd_pkg.sv -----
// Shared constants, types and codes for the page-organized monochrome drawing engine.
// Used by mpfd_ram, mpfd_engine and the top level; depends on nothing else.
`timescale 1ns / 1ps

package mpfd_pkg;

  localparam int COLUMNS    = 128;
  localparam int ROWS       = 64;
  localparam int PAGES      = (ROWS + 7) / 8;
  localparam int STORE_SIZE = PAGES * COLUMNS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic [7:0] COL_LIM  = 8'(COLUMNS);
  localparam logic [7:0] ROW_LIM  = 8'(ROWS);
  localparam logic [7:0] COL_LAST = 8'(COLUMNS - 1);
  localparam logic [7:0] ROW_LAST = 8'(ROWS - 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PAGE_W-1:0] page_t;

  typedef enum logic [2:0] {
    CMD_POINT = 3'd0,
    CMD_READ  = 3'd1,
    CMD_HLINE = 3'd2,
    CMD_VLINE = 3'd3,
    CMD_RECT  = 3'd4,
    CMD_FILL  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_CLR,
    OP_XOR,
    OP_READ,
    OP_FILL
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_SWEEP,
    ST_FINISH
  } eng_state_t;

  typedef struct packed {
    op_t        op;
    logic       ok;
    logic [7:0] col_lo;
    logic [7:0] col_hi;
    logic [7:0] row_lo;
    logic [7:0] row_hi;
    logic [7:0] fill;
  } job_t;

  typedef struct packed {
    logic idle;
    logic fin;
    logic ok;
    logic pixel;
  } eng_stat_t;

  typedef struct packed {
    logic       rd;
    logic       wr;
    addr_t      addr;
    logic [7:0] wdata;
  } ram_req_t;

endpackage

// ----- design/mpfd_ram.sv -----
// Single-port frame store with registered read.
// Depends on mpfd_pkg for its depth and request type.
`timescale 1ns / 1ps

module mpfd_ram (
  input  logic              clk,
  input  mpfd_pkg::ram_req_t req,
  output logic [7:0]        rd_data
);
  import mpfd_pkg::*;

  logic [7:0] mem [STORE_SIZE];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/mpfd_engine.sv -----
// Sequencer that reads one pixel or walks the bytes of a page/column window with read-modify-write,
// and sweeps the whole store for fill and the clearing pass. Depends on mpfd_pkg.
`timescale 1ns / 1ps

module mpfd_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mpfd_pkg::job_t      job,
  input  logic                res_free,
  input  logic [7:0]          rd_data,
  output mpfd_pkg::ram_req_t  req,
  output mpfd_pkg::eng_stat_t stat
);
  import mpfd_pkg::*;

  eng_state_t state_r, state_nxt;
  addr_t      sw_r, sw_nxt;
  job_t       job_r, job_nxt;
  logic [7:0] col_r, col_nxt;
  page_t      page_r, page_nxt;
  logic       pixel_r, pixel_nxt;

  page_t      hi_page;
  page_t      lo_page;
  logic [2:0] lo_bit;
  logic [2:0] hi_bit;
  logic [7:0] mask;
  logic [7:0] new_byte;
  addr_t      cell_addr;
  logic       sw_last;

  assign lo_page   = PAGE_W'(job_r.row_lo >> 3);
  assign hi_page   = PAGE_W'(job_r.row_hi >> 3);
  assign lo_bit    = (page_r == lo_page) ? job_r.row_lo[2:0] : 3'd0;
  assign hi_bit    = (page_r == hi_page) ? job_r.row_hi[2:0] : 3'd7;
  assign mask      = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
  assign cell_addr = ADDR_W'(page_r * COLUMNS) + ADDR_W'(col_r);
  assign sw_last   = (sw_r == ADDR_W'(STORE_SIZE - 1));

  always_comb begin
    case (job_r.op)
      OP_SET:  new_byte = rd_data | mask;
      OP_CLR:  new_byte = rd_data & ~mask;
      OP_XOR:  new_byte = rd_data ^ mask;
      default: new_byte = rd_data;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sw_nxt    = sw_r;
    job_nxt   = job_r;
    col_nxt   = col_r;
    page_nxt  = page_r;
    pixel_nxt = pixel_r;
    req.rd    = 1'b0;
    req.wr    = 1'b0;
    req.addr  = cell_addr;
    req.wdata = new_byte;
    case (state_r)
      ST_CLEAR: begin
        req.wr    = 1'b1;
        req.addr  = sw_r;
        req.wdata = 8'h00;
        if (sw_last) begin
          sw_nxt    = '0;
          state_nxt = ST_IDLE;
        end else begin
          sw_nxt = sw_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          job_nxt   = job;
          col_nxt   = job.col_lo;
          page_nxt  = PAGE_W'(job.row_lo >> 3);
          pixel_nxt = 1'b0;
          sw_nxt    = '0;
          case (job.op)
            OP_NONE: state_nxt = ST_FINISH;
            OP_FILL: state_nxt = ST_SWEEP;
            default: state_nxt = ST_READ;
          endcase
        end
      end
      ST_READ: begin
        req.rd    = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (job_r.op == OP_READ) begin
          pixel_nxt = rd_data[job_r.row_lo[2:0]];
          state_nxt = ST_FINISH;
        end else begin
          req.wr = 1'b1;
          if (col_r == job_r.col_hi) begin
            if (page_r == hi_page) begin
              state_nxt = ST_FINISH;
            end else begin
              page_nxt  = page_r + 1'b1;
              col_nxt   = job_r.col_lo;
              state_nxt = ST_READ;
            end
          end else begin
            col_nxt   = col_r + 8'd1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_SWEEP: begin
        req.wr    = 1'b1;
        req.addr  = sw_r;
        req.wdata = job_r.fill;
        if (sw_last) begin
          state_nxt = ST_FINISH;
        end else begin
          sw_nxt = sw_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      sw_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sw_r    <= sw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    col_r   <= col_nxt;
    page_r  <= page_nxt;
    pixel_r <= pixel_nxt;
  end

  assign stat.idle  = (state_r == ST_IDLE);
  assign stat.fin   = (state_r == ST_FINISH);
  assign stat.ok    = job_r.ok;
  assign stat.pixel = pixel_r;

endmodule

// ----- design/mono_page_framebuffer_draw_top.sv -----
// Top level of the monochrome page frame buffer drawing engine: command decode,
// bounds checks and the result register. Depends on mpfd_pkg, mpfd_engine and mpfd_ram.
`timescale 1ns / 1ps

// The engine takes one command word at a time and returns one result word per command.
// After reset it first clears the 1024-byte frame store, one byte per cycle, and
// holds in_stall high until that pass is done. A point, line or rectangle reads and
// then writes each store byte it touches, a read only reads its byte, a rejected or
// empty command goes straight to its result, and a fill writes every byte of the store;
// in_stall stays high until the result is in the output register. A finished result
// waits in the output register while the next word is taken.
module mono_page_framebuffer_draw_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_x,
  input  logic [7:0] in_y,
  input  logic [7:0] in_x_end,
  input  logic [7:0] in_y_end,
  input  logic [7:0] in_rect_width,
  input  logic [7:0] in_rect_height,
  input  logic       in_color,
  input  logic [7:0] in_fill_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic       out_pixel
);
  import mpfd_pkg::*;

  job_t       job;
  eng_stat_t  stat;
  ram_req_t   req;
  logic [7:0] rd_data;
  logic       start;
  logic       res_free;

  logic       x_in;
  logic       y_in;
  logic [7:0] hx_lo;
  logic [7:0] hx_hi;
  logic [7:0] vy_lo;
  logic [7:0] vy_hi;
  logic [8:0] rc_sum;
  logic [8:0] rr_sum;

  logic       out_valid_r;
  logic       out_ok_r;
  logic       out_pixel_r;

  assign x_in   = (in_x < COL_LIM);
  assign y_in   = (in_y < ROW_LIM);
  assign hx_lo  = (in_x < in_x_end) ? in_x : in_x_end;
  assign hx_hi  = (in_x < in_x_end) ? in_x_end : in_x;
  assign vy_lo  = (in_y < in_y_end) ? in_y : in_y_end;
  assign vy_hi  = (in_y < in_y_end) ? in_y_end : in_y;
  assign rc_sum = {1'b0, in_x} + {1'b0, in_rect_width} - 9'd1;
  assign rr_sum = {1'b0, in_y} + {1'b0, in_rect_height} - 9'd1;

  always_comb begin
    job.op     = OP_NONE;
    job.ok     = 1'b0;
    job.col_lo = in_x;
    job.col_hi = in_x;
    job.row_lo = in_y;
    job.row_hi = in_y;
    job.fill   = in_fill_byte;
    case (in_cmd)
      CMD_POINT: begin
        if (x_in && y_in) begin
          job.ok = 1'b1;
          job.op = in_color ? OP_SET : OP_CLR;
        end
      end
      CMD_READ: begin
        if (x_in && y_in) begin
          job.ok = 1'b1;
          job.op = OP_READ;
        end
      end
      CMD_HLINE: begin
        if (y_in && (hx_lo < COL_LIM)) begin
          job.ok     = 1'b1;
          job.op     = in_color ? OP_SET : OP_CLR;
          job.col_lo = hx_lo;
          job.col_hi = (hx_hi >= COL_LIM) ? COL_LAST : hx_hi;
        end
      end
      CMD_VLINE: begin
        if (x_in && (vy_lo < ROW_LIM)) begin
          job.ok     = 1'b1;
          job.op     = in_color ? OP_SET : OP_CLR;
          job.row_lo = vy_lo;
          job.row_hi = (vy_hi >= ROW_LIM) ? ROW_LAST : vy_hi;
        end
      end
      CMD_RECT: begin
        if (x_in && y_in && (in_rect_width < COL_LIM) && (in_rect_height < ROW_LIM)) begin
          job.ok = 1'b1;
          if ((in_rect_width != 8'd0) && (in_rect_height != 8'd0)) begin
            job.op = OP_XOR;
          end
          job.col_hi = (rc_sum >= {1'b0, COL_LIM}) ? COL_LAST : rc_sum[7:0];
          job.row_hi = (rr_sum >= {1'b0, ROW_LIM}) ? ROW_LAST : rr_sum[7:0];
        end
      end
      CMD_FILL: begin
        job.ok = 1'b1;
        job.op = OP_FILL;
      end
      default: begin
        job.op = OP_NONE;
      end
    endcase
  end

  assign in_stall = !stat.idle;
  assign start    = in_valid && stat.idle;
  assign res_free = !out_valid_r || !out_stall;

  mpfd_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .job      (job),
    .res_free (res_free),
    .rd_data  (rd_data),
    .req      (req),
    .stat     (stat)
  );

  mpfd_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.fin && res_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.fin && res_free) begin
      out_ok_r    <= stat.ok;
      out_pixel_r <= stat.pixel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_pixel = out_pixel_r;

endmodule

// ----- design/mpfd_checker.sv -----
// Port-level checks for the drawing engine and the bind that attaches them.
// Depends on mono_page_framebuffer_draw_top.
`timescale 1ns / 1ps

module mpfd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_ok,
  input logic out_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_ok) && $stable(out_pixel))
    else $error("stalled result word changed");

  a_pixel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel |-> out_ok)
    else $error("pixel set on a rejected command");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken before the first one finished");

  a_clear_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_stall)
    else $error("input taken during the clearing pass");

endmodule

bind mono_page_framebuffer_draw_top mpfd_checker u_mpfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_ok    (out_ok),
  .out_pixel (out_pixel)
);
